// ----- design/irg_pkg.sv -----
// Package for the ISAAC generator: sizes, command codes, controller/datapath interface.
// Used by every module in the design folder; depends on nothing.
`default_nettype none
package irg_pkg;
  localparam int unsigned TableSize = 256;
  localparam int unsigned TableLog2 = 8;
  localparam logic [31:0] Golden = 32'h9e3779b9;

  typedef logic [TableLog2-1:0] idx_t;
  typedef logic [TableLog2:0] cnt_t;
  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_NEXT   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_SEEDED = 2'd2,
    CMD_PLAIN  = 2'd3
  } cmd_t;

  // Datapath operations requested by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,     // clear accumulators, load golden constants
    OP_SCRAMBLE, // one line k of the scramble of the mixer registers
    OP_PRD_RD,   // table pass: read table/buffer word at idx
    OP_PADD,     // table pass: add read word(s) into mixer k
    OP_PWR,      // table pass: write mixer k to table
    OP_RSTART,   // round start: counter++, b = b + counter
    OP_R1,       // round: read table[i] and table[i+half]
    OP_R2,       // round: compute a, read table[x>>2]
    OP_R3,       // round: compute y, write table[i], read table[y>>10]
    OP_R4,       // round: compute b, write buffer[i]
    OP_NEXT_RD,  // read result buffer at idx
    OP_LOAD      // write seed word at idx
  } op_t;

  typedef struct packed {
    op_t          op;
    idx_t         idx;
    logic [2:0]   k;
    logic         with_seed;
    logic         with_table;
    logic         seed_valid;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ----- design/isaac_random_generator.sv -----
// Top level of the ISAAC generator: connects controller and datapath.
// Depends on irg_pkg, irg_controller and irg_datapath.
//
//   channel | ports                           | direction
//   in      | in_valid/in_stall, command, seed | into block
//   out     | out_valid/out_stall, value       | out of block
//
// A next request reads a result word, then waits for the output; a load (or an
// ignored load, seed buffer full) leaves the block idle. With no result words left,
// a next first runs a refill round: a counter step, then phases R1 to R4 per table
// word. An init scrambles, passes over the table eight words at a time (seed and
// table passes if seeded) and runs a round. The scramble runs one line per cycle.
// After reset an unseeded init runs; in_stall is high until it ends.
// The result is held in out_random_value while out_stall is high.
`default_nettype none
module isaac_random_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_seed_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_random_value
);
  irg_pkg::dp_cmd_t cmd;

  irg_controller u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .out_valid, .out_stall, .cmd
  );

  irg_datapath u_dp (
    .clk, .cmd, .seed_word(in_seed_word), .rd_word(out_random_value)
  );

`ifndef ASSERT_OFF
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_value))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ----- design/irg_datapath.sv -----
// Datapath of the ISAAC generator: table and result memories, mixer, accumulators.
// Depends on irg_pkg; driven by irg_controller through dp_cmd_t.
`default_nettype none
module irg_datapath (
  input  wire logic             clk,
  input  wire irg_pkg::dp_cmd_t cmd,
  input  wire irg_pkg::word_t   seed_word,
  output irg_pkg::word_t        rd_word
);
  irg_pkg::word_t tbl_mem [irg_pkg::TableSize];
  irg_pkg::word_t buf_mem [irg_pkg::TableSize];
  irg_pkg::word_t mix_r [8];
  irg_pkg::word_t mix_nxt [8];
  irg_pkg::word_t a_r, b_r, cnt_r, x_r, t_r, a_f, m_nxt, y_r;
  logic           fwd_r;
  irg_pkg::word_t tq_r, bq_r;
  irg_pkg::word_t y_w, b_w;
  irg_pkg::idx_t  ta, tb;
  logic           t_we, b_we;
  irg_pkg::idx_t  t_wa, b_wa;
  irg_pkg::word_t t_wd, b_wd;
  irg_pkg::idx_t  half;
  irg_pkg::word_t sh, sx;
  logic [2:0]     sp, sq, sr, ss;

  assign half = irg_pkg::idx_t'(irg_pkg::TableSize / 2);

  always_comb begin
    case (cmd.idx[1:0])
      2'd0: a_f = a_r ^ (a_r << 13);
      2'd1: a_f = a_r ^ (a_r >> 6);
      2'd2: a_f = a_r ^ (a_r << 2);
      default: a_f = a_r ^ (a_r >> 16);
    endcase
  end

  assign y_w = tq_r + a_r + b_r;
  // When y selects the word just written, the table read returned the old value.
  assign b_w = (fwd_r ? y_r : tq_r) + x_r;

  // One line of the scramble per cycle; the controller steps cmd.k through all eight.
  always_comb begin
    sp = cmd.k;
    sq = cmd.k + 3'd1;
    sr = cmd.k + 3'd2;
    ss = cmd.k + 3'd3;
    case (cmd.k)
      3'd0: sh = mix_r[sq] << 11;
      3'd1: sh = mix_r[sq] >> 2;
      3'd2: sh = mix_r[sq] << 8;
      3'd3: sh = mix_r[sq] >> 16;
      3'd4: sh = mix_r[sq] << 10;
      3'd5: sh = mix_r[sq] >> 4;
      3'd6: sh = mix_r[sq] << 8;
      default: sh = mix_r[sq] >> 9;
    endcase
    sx = mix_r[sp] ^ sh;
    for (int j = 0; j < 8; j++) mix_nxt[j] = mix_r[j];
    mix_nxt[sp] = sx;
    mix_nxt[ss] = mix_r[ss] + sx;
    mix_nxt[sq] = mix_r[sq] + mix_r[sr];
  end

  always_comb begin
    m_nxt = mix_r[cmd.k];
    if (cmd.with_seed && cmd.seed_valid) m_nxt = m_nxt + bq_r;
    if (cmd.with_table) m_nxt = m_nxt + tq_r;
  end

  // Memory addressing for the current operation.
  always_comb begin
    ta = cmd.idx;
    tb = cmd.idx;
    t_we = 1'b0; t_wa = cmd.idx; t_wd = mix_r[cmd.k];
    b_we = 1'b0; b_wa = cmd.idx; b_wd = seed_word;
    case (cmd.op)
      irg_pkg::OP_R1: tb = cmd.idx + half;
      irg_pkg::OP_R2: ta = tq_r[irg_pkg::TableLog2+1:2];
      irg_pkg::OP_R3: begin
        ta = y_w[2*irg_pkg::TableLog2+1:irg_pkg::TableLog2+2];
        t_we = 1'b1; t_wd = y_w;
      end
      irg_pkg::OP_R4: begin
        b_we = 1'b1; b_wd = b_w;
      end
      irg_pkg::OP_PWR: t_we = 1'b1;
      irg_pkg::OP_LOAD: b_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) tbl_mem[t_wa] <= t_wd;
    if (b_we) buf_mem[b_wa] <= b_wd;
    tq_r <= tbl_mem[ta];
    bq_r <= buf_mem[cmd.idx];
    t_r  <= tbl_mem[tb];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      irg_pkg::OP_INIT: begin
        a_r <= '0; b_r <= '0; cnt_r <= '0;
        for (int j = 0; j < 8; j++) mix_r[j] <= irg_pkg::Golden;
      end
      irg_pkg::OP_SCRAMBLE: for (int j = 0; j < 8; j++) mix_r[j] <= mix_nxt[j];
      irg_pkg::OP_PADD: mix_r[cmd.k] <= m_nxt;
      irg_pkg::OP_RSTART: begin
        cnt_r <= cnt_r + 32'd1;
        b_r   <= b_r + cnt_r + 32'd1;
      end
      irg_pkg::OP_R1: ;
      irg_pkg::OP_R2: begin
        x_r <= tq_r;
        a_r <= a_f + t_r;
      end
      irg_pkg::OP_R3: begin
        fwd_r <= (ta == cmd.idx);
        y_r   <= y_w;
      end
      irg_pkg::OP_R4: b_r <= b_w;
      default: ;
    endcase
  end

  assign rd_word = bq_r;
endmodule
`default_nettype wire

// ----- design/irg_controller.sv -----
// Controller of the ISAAC generator: sequences init passes, rounds and requests.
// Depends on irg_pkg; commands irg_datapath through dp_cmd_t.
`default_nettype none
module irg_controller (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_command,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output irg_pkg::dp_cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_INIT  = 10'b0000000010,
    S_SCR   = 10'b0000000100,
    S_PRD   = 10'b0000001000,
    S_PADD  = 10'b0000010000,
    S_PSCR  = 10'b0000100000,
    S_PWR   = 10'b0001000000,
    S_RND   = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  irg_pkg::cnt_t left_r, left_nxt, seeds_r, seeds_nxt;
  irg_pkg::cnt_t idx_r, idx_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [1:0] pass_r, pass_nxt;  // 0 plain, 1 seed pass, 2 table pass
  logic [2:0] ph_r, ph_nxt;      // round phase
  logic       nround_r, nround_nxt; // round started by a next request
  logic       take;
  irg_pkg::cmd_t c;

  assign c = irg_pkg::cmd_t'(in_command);
  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r; left_nxt = left_r; seeds_nxt = seeds_r;
    idx_nxt = idx_r; sub_nxt = sub_r; pass_nxt = pass_r; ph_nxt = ph_r;
    nround_nxt = nround_r;
    cmd = '0;
    cmd.op = irg_pkg::OP_NONE;
    cmd.idx = idx_r[irg_pkg::TableLog2-1:0];
    cmd.k = sub_r;
    cmd.with_seed = (pass_r == 2'd1);
    cmd.with_table = (pass_r == 2'd2);
    cmd.seed_valid = (idx_r < seeds_r);
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: if (take) begin
        case (c)
          irg_pkg::CMD_NEXT: begin
            if (left_r == '0) begin
              state_nxt = S_RND; idx_nxt = '0; ph_nxt = '0; nround_nxt = 1'b1;
              cmd.op = irg_pkg::OP_RSTART;
            end else begin
              state_nxt = S_NEXT;
            end
          end
          irg_pkg::CMD_LOAD: if (seeds_r < irg_pkg::cnt_t'(irg_pkg::TableSize)) begin
            cmd.op = irg_pkg::OP_LOAD;
            cmd.idx = seeds_r[irg_pkg::TableLog2-1:0];
            seeds_nxt = seeds_r + 1'b1;
          end
          default: begin
            state_nxt = S_INIT;
            pass_nxt = (c == irg_pkg::CMD_SEEDED && seeds_r != '0) ? 2'd1 : 2'd0;
          end
        endcase
      end
      S_INIT: begin
        cmd.op = irg_pkg::OP_INIT;
        state_nxt = S_SCR; idx_nxt = '0; sub_nxt = '0;
      end
      S_SCR: begin
        // Four full scrambles, one line per cycle.
        cmd.op = irg_pkg::OP_SCRAMBLE;
        cmd.k = idx_r[2:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == irg_pkg::cnt_t'(31)) begin
          state_nxt = S_PRD; idx_nxt = '0; sub_nxt = '0;
        end
      end
      S_PRD: begin
        cmd.op = irg_pkg::OP_PRD_RD;
        state_nxt = S_PADD;
      end
      S_PADD: begin
        cmd.op = irg_pkg::OP_PADD;
        idx_nxt = idx_r + 1'b1;
        sub_nxt = sub_r + 1'b1;
        state_nxt = (sub_r == 3'd7) ? S_PSCR : S_PRD;
      end
      S_PSCR: begin
        cmd.op = irg_pkg::OP_SCRAMBLE;
        sub_nxt = sub_r + 1'b1;
        if (sub_r == 3'd7) begin
          idx_nxt = idx_r - irg_pkg::cnt_t'(8);
          state_nxt = S_PWR;
        end
      end
      S_PWR: begin
        cmd.op = irg_pkg::OP_PWR;
        idx_nxt = idx_r + 1'b1;
        sub_nxt = sub_r + 1'b1;
        if (sub_r == 3'd7) begin
          if (idx_nxt != irg_pkg::cnt_t'(irg_pkg::TableSize)) begin
            state_nxt = S_PRD;
          end else if (pass_r == 2'd1) begin
            pass_nxt = 2'd2; idx_nxt = '0; state_nxt = S_PRD;
          end else begin
            state_nxt = S_RND; idx_nxt = '0; ph_nxt = 3'd4; nround_nxt = 1'b0;
            cmd.op = irg_pkg::OP_PWR;
          end
        end
      end
      S_RND: begin
        // Four phases per table word; the first cycle of a round bumps the counter.
        if (ph_r == 3'd4) begin
          cmd.op = irg_pkg::OP_RSTART; ph_nxt = '0;
        end else begin
          case (ph_r)
            3'd0: cmd.op = irg_pkg::OP_R1;
            3'd1: cmd.op = irg_pkg::OP_R2;
            3'd2: cmd.op = irg_pkg::OP_R3;
            default: cmd.op = irg_pkg::OP_R4;
          endcase
          ph_nxt = ph_r + 1'b1;
          if (ph_r == 3'd3) begin
            ph_nxt = '0;
            idx_nxt = idx_r + 1'b1;
            if (idx_r == irg_pkg::cnt_t'(irg_pkg::TableSize - 1)) begin
              left_nxt = irg_pkg::cnt_t'(irg_pkg::TableSize);
              seeds_nxt = nround_r ? seeds_r : '0;
              state_nxt = nround_r ? S_NEXT : S_IDLE;
            end
          end
        end
      end
      S_NEXT: begin
        cmd.op = irg_pkg::OP_NEXT_RD;
        left_nxt = left_r - 1'b1;
        cmd.idx = left_nxt[irg_pkg::TableLog2-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Keep reading the same buffer word so the result holds while stalled.
        cmd.idx = left_r[irg_pkg::TableLog2-1:0];
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // After reset the block runs an unseeded init on its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; left_r <= '0; seeds_r <= '0; idx_r <= '0;
      sub_r <= '0; pass_r <= '0; ph_r <= '0; nround_r <= 1'b0;
    end else begin
      state_r <= state_nxt; left_r <= left_nxt; seeds_r <= seeds_nxt;
      idx_r <= idx_nxt; sub_r <= sub_nxt; pass_r <= pass_nxt;
      ph_r <= ph_nxt; nround_r <= nround_nxt;
    end
  end
endmodule
`default_nettype wire
